// File: rtl/core/msrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// msrc_pkg
// Shared types, codes and the CRC-16 byte update for the sensor reply checker.
// ---------------------------------------------------------------------------
package msrc_pkg;

  localparam int unsigned MaxFrameDefault = 64;
  localparam int unsigned PosWidth        = 7;   // holds any frame limit up to 127
  localparam int unsigned NumWords        = 6;
  localparam int unsigned WordWidth       = 16;
  localparam int unsigned FirstFieldPos   = 3;
  localparam int unsigned LastFieldPos    = 14;

  localparam logic [15:0] CrcInit       = 16'hFFFF;
  localparam logic [15:0] CrcPoly       = 16'hA001;
  localparam logic [15:0] TickMax       = 16'hFFFF;
  localparam logic [15:0] TimeoutReset  = 16'd1000;

  // operation codes carried on s_tuser
  localparam logic [1:0] OpStart = 2'd0;
  localparam logic [1:0] OpByte  = 2'd1;
  localparam logic [1:0] OpTick  = 2'd2;

  // status codes carried on m_tuser
  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusCrcErr  = 2'd1;
  localparam logic [1:0] StatusTimeout = 2'd2;

  // configuration register index
  localparam logic RegTimeout = 1'b0;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_BUSY = 3'b010,
    PH_DONE = 3'b100
  } phase_t;

  typedef logic [WordWidth-1:0] word_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
    logic       frame_end;
  } item_t;

  typedef struct packed {
    logic                       valid;
    logic [1:0]                 status;
    logic [NumWords-1:0][15:0]  words;
  } result_t;

  // reflected CRC-16, one byte, eight bit steps unrolled
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage : msrc_pkg
`default_nettype wire

// File: rtl/core/msrc_frame_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// msrc_frame_check
// Frame state for one reply: phase, CRC, delay line, byte count, tick count
// and captured words. Takes one item per step and forms the result.
// ---------------------------------------------------------------------------
module msrc_frame_check #(
  parameter int unsigned MAX_FRAME = msrc_pkg::MaxFrameDefault
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire msrc_pkg::item_t item,
  input  wire logic [15:0]     timeout_ticks,
  output msrc_pkg::result_t    result
);
  import msrc_pkg::*;

  localparam logic [PosWidth-1:0] PosLimit = PosWidth'(MAX_FRAME);
  localparam logic [PosWidth-1:0] PosFirst = PosWidth'(FirstFieldPos);
  localparam logic [PosWidth-1:0] PosLast  = PosWidth'(LastFieldPos);

  phase_t                    phase, phase_next;
  logic [15:0]               crc_accum, crc_accum_next;
  logic [PosWidth-1:0]       byte_position, byte_position_next;
  logic [7:0]                held0, held0_next, held1, held1_next;
  logic [15:0]               elapsed_ticks, elapsed_ticks_next;
  logic [NumWords-1:0][15:0] field_words, field_words_next;

  logic [PosWidth-1:0]       rel;
  logic [2:0]                widx;
  logic [15:0]               crc_upd;
  logic [15:0]               tick_inc;

  always_comb begin
    phase_next         = phase;
    crc_accum_next     = crc_accum;
    byte_position_next = byte_position;
    held0_next         = held0;
    held1_next         = held1;
    elapsed_ticks_next = elapsed_ticks;
    field_words_next   = field_words;
    result             = '0;

    rel      = byte_position - PosFirst;
    widx     = rel[3:1];
    crc_upd  = (byte_position >= PosWidth'(2)) ? crc_byte(crc_accum, held0) : crc_accum;
    tick_inc = (elapsed_ticks != TickMax) ? elapsed_ticks + 16'd1 : elapsed_ticks;

    if (step) begin
      if (item.operation == OpStart) begin
        phase_next         = PH_BUSY;
        crc_accum_next     = CrcInit;
        byte_position_next = '0;
        held0_next         = '0;
        held1_next         = '0;
        elapsed_ticks_next = '0;
        field_words_next   = '0;
      end else if (phase == PH_BUSY) begin
        case (item.operation)
          OpByte: begin
            if (byte_position >= PosFirst && byte_position <= PosLast) begin
              // even offset is the high byte of a big-endian word
              if (!rel[0]) begin
                field_words_next[widx][15:8] = item.rx_byte;
              end else begin
                field_words_next[widx][7:0] = item.rx_byte;
              end
            end
            crc_accum_next = crc_upd;
            held0_next     = held1;
            held1_next     = item.rx_byte;
            if (byte_position < PosLimit) begin
              byte_position_next = byte_position + PosWidth'(1);
            end
            if (item.frame_end) begin
              phase_next   = PH_DONE;
              result.valid = 1'b1;
              if (byte_position < PosWidth'(2)) begin
                result.status = StatusCrcErr;
              end else if (crc_upd != {item.rx_byte, held1}) begin
                result.status = StatusCrcErr;
              end else begin
                result.status = StatusOk;
                result.words  = field_words_next;
              end
            end
          end
          OpTick: begin
            elapsed_ticks_next = tick_inc;
            if (tick_inc >= timeout_ticks) begin
              phase_next    = PH_DONE;
              result.valid  = 1'b1;
              result.status = StatusTimeout;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      crc_accum     <= CrcInit;
      byte_position <= '0;
      held0         <= '0;
      held1         <= '0;
      elapsed_ticks <= '0;
      field_words   <= '0;
    end else begin
      phase         <= phase_next;
      crc_accum     <= crc_accum_next;
      byte_position <= byte_position_next;
      held0         <= held0_next;
      held1         <= held1_next;
      elapsed_ticks <= elapsed_ticks_next;
      field_words   <= field_words_next;
    end
  end

endmodule : msrc_frame_check
`default_nettype wire

// File: rtl/core/modbus_sensor_reply_checker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// modbus_sensor_reply_checker_core
// Checks one Modbus RTU sensor reply: CRC-16 over the frame, trailing CRC
// compare, capture of the time words and reading, and a tick timeout.
// ---------------------------------------------------------------------------
//  channel   direction  payload
//  s_*       in         tdata rx_byte, tuser operation, tlast frame_end
//  m_*       out        tdata six 16-bit words, tuser status
//  apb       in/out     timeout_ticks at address 0x0
//
// One item per cycle while the result stream is not stalled; an accepted item
// sits in the input register, and its result passes through the frame update
// with its unrolled byte-wide CRC step into the result register.
// Synchronous reset sets the block idle and timeout_ticks to 1000; it
// accepts items in the first cycle after reset.
// A stalled result holds both stages; s_tready drops only when the input
// register is full and cannot move on.
// ---------------------------------------------------------------------------
module modbus_sensor_reply_checker_core #(
  parameter int unsigned MAX_FRAME = msrc_pkg::MaxFrameDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic [1:0]  s_tuser,   // [1:0] operation
  input  wire logic        s_tlast,   // frame_end
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [95:0]      m_tdata,   // reading_raw, year, month, day, hour, minute
  output logic [1:0]       m_tuser,   // [1:0] status
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import msrc_pkg::*;

  logic        in_valid;
  item_t       in_item;
  logic        advance;
  logic [15:0] timeout_ticks;
  result_t     result;

  // the frame stage moves whenever the result register is free or draining
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item <= '{operation: s_tuser, rx_byte: s_tdata, frame_end: s_tlast};
    end
  end

  msrc_frame_check #(
    .MAX_FRAME(MAX_FRAME)
  ) u_frame (
    .clk          (clk),
    .rst          (rst),
    .step         (in_valid && advance),
    .item         (in_item),
    .timeout_ticks(timeout_ticks),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      m_tuser <= result.status;
      m_tdata <= {result.words[4], result.words[3], result.words[2],
                  result.words[1], result.words[0], result.words[5]};
    end
  end

  // APB register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TimeoutReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegTimeout) begin
      timeout_ticks <= pwdata[15:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegTimeout: prdata = {16'h0000, timeout_ticks};
      default:    prdata = '0;
    endcase
  end

endmodule : modbus_sensor_reply_checker_core
`default_nettype wire

// File: rtl/core/msrc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// msrc_checker
// Port-level checks on the result stream of the reply checker.
// ---------------------------------------------------------------------------
module msrc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [95:0] m_tdata,
  input wire logic [1:0]  m_tuser
);
  import msrc_pkg::*;

  // a pending result transaction holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == StatusOk || m_tuser == StatusCrcErr ||
                  m_tuser == StatusTimeout))
    else $error("status code out of range");

  // error results carry no words
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != StatusOk |-> m_tdata == '0)
    else $error("error result with nonzero words");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a result needs an item in the pipeline, so none appears in the cycle after reset release
  a_no_early: assert property (@(posedge clk)
    $past(rst) && !rst |-> !m_tvalid && s_tready)
    else $error("result or stall right after reset");

endmodule : msrc_checker

bind modbus_sensor_reply_checker_core msrc_checker u_msrc_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the sensor reply checker: a directed table walks
// the corner cases, then random frames, tick bursts and noise run under
// several timeout settings and idling patterns. A behavioral reply model
// predicts results not set by a directed row; each is compared field by field.
// ---------------------------------------------------------------------------
module testbench;
  import msrc_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam logic [1:0] TailNone = 2'd0;
  localparam logic [1:0] TailLo   = 2'd1;
  localparam logic [1:0] TailHi   = 2'd2;
  localparam int QuietLimit = 3000;
  localparam int PhaseItems = 120;

  // one row of the directed table; tail rows carry the running frame CRC
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic       last;
    logic [1:0] tail;
    logic       typed;
    logic [1:0] status;
  } row_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic       last;
    logic       typed;
    logic [1:0] status;
  } stim_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [95:0] words;
  } reply_t;

  localparam row_t DIRECTED_ROWS [0:27] = '{
    '{OpTick,   8'h00, 1'b1, TailNone, 1'b0, StatusOk},      // idle: ignored
    '{OpStart,  8'hFF, 1'b1, TailNone, 1'b0, StatusOk},
    '{OpByte,   8'h5A, 1'b1, TailNone, 1'b1, StatusCrcErr},  // one-byte frame
    '{OpByte,   8'hFF, 1'b1, TailNone, 1'b0, StatusOk},      // done: ignored
    '{OpStart,  8'h00, 1'b0, TailNone, 1'b0, StatusOk},
    '{OpByte,   8'h01, 1'b0, TailNone, 1'b0, StatusOk},
    '{OpByte,   8'h03, 1'b0, TailNone, 1'b0, StatusOk},
    '{OpByte,   8'h0C, 1'b0, TailNone, 1'b0, StatusOk},
    '{OpByte,   8'hFF, 1'b0, TailNone, 1'b0, StatusOk},
    '{OpByte,   8'hFF, 1'b0, TailNone, 1'b0, StatusOk},
    '{OpByte,   8'h00, 1'b0, TailNone, 1'b0, StatusOk},
    '{OpByte,   8'h00, 1'b0, TailNone, 1'b0, StatusOk},
    '{OpByte,   8'h80, 1'b0, TailNone, 1'b0, StatusOk},
    '{OpUnused, 8'hFF, 1'b1, TailNone, 1'b0, StatusOk},      // unused code mid-frame
    '{OpByte,   8'h01, 1'b0, TailNone, 1'b0, StatusOk},
    '{OpByte,   8'h7F, 1'b0, TailNone, 1'b0, StatusOk},
    '{OpByte,   8'hFE, 1'b0, TailNone, 1'b0, StatusOk},
    '{OpByte,   8'hA5, 1'b0, TailNone, 1'b0, StatusOk},
    '{OpByte,   8'h5A, 1'b0, TailNone, 1'b0, StatusOk},
    '{OpByte,   8'h00, 1'b0, TailLo,   1'b0, StatusOk},
    '{OpByte,   8'h00, 1'b1, TailHi,   1'b0, StatusOk},      // good frame, predicted
    '{OpStart,  8'h00, 1'b0, TailNone, 1'b0, StatusOk},
    '{OpTick,   8'h00, 1'b0, TailNone, 1'b0, StatusOk},
    '{OpTick,   8'h00, 1'b0, TailNone, 1'b1, StatusTimeout}, // limit is 2 here
    '{OpStart,  8'h00, 1'b0, TailNone, 1'b0, StatusOk},
    '{OpByte,   8'h00, 1'b0, TailNone, 1'b0, StatusOk},
    '{OpByte,   8'h00, 1'b0, TailNone, 1'b0, StatusOk},
    '{OpByte,   8'h00, 1'b1, TailNone, 1'b1, StatusCrcErr}   // bad trailing CRC
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] rx_byte
  logic [1:0]  s_tuser = '0;   // [1:0] operation
  logic        s_tlast = 1'b0; // frame_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;        // [15:0] reading_raw, then year, month, day, hour, minute
  logic [1:0]  m_tuser;        // [1:0] status
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  modbus_sensor_reply_checker_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // reply model state
  phase_t      mdl_phase = PH_IDLE;
  logic [15:0] mdl_crc = CrcInit;
  int          mdl_pos = 0;
  logic [7:0]  mdl_held0 = '0, mdl_held1 = '0;
  logic [15:0] mdl_ticks = '0;
  logic [15:0] mdl_words [0:5] = '{default: '0};
  logic [15:0] mdl_timeout = TimeoutReset;

  stim_t  send_q [$];
  reply_t pending_replies [$];
  stim_t  on_bus;
  int     tx_idle_pct = 0;
  int     rx_stall_pct = 0;
  int     hold_left = 0;
  int     queued_items = 0;
  int     mismatch_count = 0;
  int     accepted_items = 0;
  int     quiet_cycles = 0;
  int     seen_ok = 0, seen_crc = 0, seen_timeout = 0;
  string  word_names [0:5] = '{"reading_raw", "year", "month", "day", "hour", "minute"};

  function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    return c;
  endfunction

  task automatic predict_reply(input stim_t it, output bit got, output reply_t r);
    int p;
    got = 1'b0;
    r = '0;
    if (it.op == OpStart) begin
      mdl_phase = PH_BUSY;
      mdl_crc = CrcInit;
      mdl_pos = 0;
      mdl_held0 = '0;
      mdl_held1 = '0;
      mdl_ticks = '0;
      foreach (mdl_words[k]) mdl_words[k] = '0;
    end else if (mdl_phase == PH_BUSY && it.op == OpByte) begin
      p = mdl_pos;
      if (p >= FirstFieldPos && p <= LastFieldPos) begin
        if (((p - 3) & 1) == 0) mdl_words[(p - 3) >> 1][15:8] = it.data;
        else mdl_words[(p - 3) >> 1][7:0] = it.data;
      end
      // two-byte delay keeps the trailing CRC out of the running CRC
      if (p >= 2) mdl_crc = crc16_update(mdl_crc, mdl_held0);
      mdl_held0 = mdl_held1;
      mdl_held1 = it.data;
      if (p < MaxFrameDefault) mdl_pos = p + 1;
      if (it.last) begin
        mdl_phase = PH_DONE;
        got = 1'b1;
        if (p + 1 < 3 || mdl_crc != {mdl_held1, mdl_held0}) begin
          r.status = StatusCrcErr;
        end else begin
          r.status = StatusOk;
          r.words = {mdl_words[4], mdl_words[3], mdl_words[2], mdl_words[1],
                     mdl_words[0], mdl_words[5]};
        end
      end
    end else if (mdl_phase == PH_BUSY && it.op == OpTick) begin
      if (mdl_ticks != TickMax) mdl_ticks = mdl_ticks + 16'd1;
      if (mdl_ticks >= mdl_timeout) begin
        mdl_phase = PH_DONE;
        got = 1'b1;
        r.status = StatusTimeout;
      end
    end
  endtask

  // stream driver, input capture, result check and watchdog
  always @(posedge clk) begin : stream_io
    reply_t r;
    reply_t want;
    bit     got;
    bit     moved;
    moved = 1'b0;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        moved = 1'b1;
        case (m_tuser)
          StatusOk:      seen_ok++;
          StatusCrcErr:  seen_crc++;
          StatusTimeout: seen_timeout++;
          default: ;
        endcase
        if (pending_replies.size() == 0) begin
          $display("%0t: unexpected reply: expected none, got status %0d, data %h", $time,
                   m_tuser, m_tdata);
          mismatch_count++;
        end else begin
          want = pending_replies.pop_front();
          if (m_tuser !== want.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status,
                     m_tuser);
            mismatch_count++;
          end
          for (int k = 0; k < 6; k++) begin
            if (m_tdata[16*k +: 16] !== want.words[16*k +: 16]) begin
              $display("%0t: %s mismatch: expected %h, got %h", $time, word_names[k],
                       want.words[16*k +: 16], m_tdata[16*k +: 16]);
              mismatch_count++;
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        moved = 1'b1;
        accepted_items++;
        predict_reply(on_bus, got, r);
        if (on_bus.typed) begin
          r = '0;
          r.status = on_bus.status;
          got = 1'b1;
        end
        if (got) pending_replies.push_back(r);
      end
      if (!s_tvalid || s_tready) begin
        if (send_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          on_bus = send_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= on_bus.data;
          s_tuser <= on_bus.op;
          s_tlast <= on_bus.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      if (psel && penable && pwrite && pready) moved = 1'b1;
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, QuietLimit);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // result side: long hold-off when asked, else random stalls
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic write_timeout(input logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {RegTimeout, 2'b00};
    pwdata <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    mdl_timeout = value;
    @(negedge clk);
  endtask

  task automatic push_item(input logic [1:0] op, input logic [7:0] data, input logic last,
                           input logic typed = 1'b0, input logic [1:0] status = StatusOk);
    stim_t it;
    it.op = op;
    it.data = data;
    it.last = last;
    it.typed = typed;
    it.status = status;
    send_q.push_back(it);
    if (op != OpUnused) queued_items++;
  endtask

  task automatic run_directed();
    logic [15:0] run_crc;
    logic [7:0]  b;
    run_crc = CrcInit;
    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].op == OpStart) run_crc = CrcInit;
      case (DIRECTED_ROWS[i].tail)
        TailLo:  b = run_crc[7:0];
        TailHi:  b = run_crc[15:8];
        default: b = DIRECTED_ROWS[i].data;
      endcase
      if (DIRECTED_ROWS[i].op == OpByte && DIRECTED_ROWS[i].tail == TailNone)
        run_crc = crc16_update(run_crc, b);
      push_item(DIRECTED_ROWS[i].op, b, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].typed,
                DIRECTED_ROWS[i].status);
    end
  endtask

  // start, payload, trailing CRC (good or corrupted), ticks and noise mixed in
  task automatic push_frame(input int len, input bit good, input bit close);
    logic [7:0]  fb [$];
    logic [15:0] c;
    c = CrcInit;
    push_item(OpStart, 8'($urandom), 1'($urandom));
    for (int i = 0; i < len; i++) begin
      fb.push_back(8'($urandom));
      c = crc16_update(c, fb[i]);
    end
    if (!good) c = c ^ (16'h0001 << $urandom_range(15));
    fb.push_back(c[7:0]);
    fb.push_back(c[15:8]);
    foreach (fb[i]) begin
      if ($urandom_range(99) < 3) push_item(OpTick, 8'($urandom), 1'($urandom));
      if ($urandom_range(99) < 2) push_item(OpUnused, 8'($urandom), 1'($urandom));
      push_item(OpByte, fb[i], close && (i == fb.size() - 1));
    end
  endtask

  task automatic push_traffic(input int count);
    int goal;
    int r;
    int len;
    goal = queued_items + count;
    while (queued_items < goal) begin
      r = $urandom_range(99);
      if (r < 72) begin
        r = $urandom_range(99);
        if (r < 8) len = $urandom_range(0, 1);
        else if (r < 14) len = $urandom_range(60, 75);
        else if (r < 22) len = $urandom_range(2, 12);
        else len = $urandom_range(13, 16);
        push_frame(len, $urandom_range(99) < 80, $urandom_range(99) < 94);
      end else if (r < 86) begin
        push_item(OpStart, 8'($urandom), 1'($urandom));
        repeat ($urandom_range(0, 45)) push_item(OpTick, 8'($urandom), 1'($urandom));
      end else begin
        repeat ($urandom_range(1, 5))
          push_item(2'($urandom), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  // wait for the stream to empty, then let the pipeline settle
  task automatic drain();
    while (send_q.size() != 0 || s_tvalid || pending_replies.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_idling(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_timeout(16'd2);
    run_directed();
    drain();

    // long hold-off with a steady sender fills the block and stalls its input
    write_timeout(16'hFFFF);
    hold_left = 400;
    push_traffic(PhaseItems);
    drain();

    set_idling(78, 0);
    write_timeout(16'd1);
    push_traffic(PhaseItems);
    drain();

    set_idling(0, 78);
    write_timeout(16'($urandom_range(3, 60)));
    push_traffic(PhaseItems);
    drain();

    set_idling(12, 12);
    write_timeout(16'($urandom_range(5, 30)));
    push_traffic(PhaseItems);
    drain();

    $display("Covered %0d input transactions under timeout limits 2, 65535, 1 and two random",
             accepted_items);
    $display("Replies checked: %0d ok, %0d crc or short, %0d timeout; %0d mismatches",
             seen_ok, seen_crc, seen_timeout, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/msrc_pkg.sv
rtl/core/msrc_frame_check.sv
rtl/core/modbus_sensor_reply_checker_core.sv
rtl/core/msrc_checker.sv
tb/testbench.sv
